>>> sv/frti_pkg.sv
// frti_pkg: shared types and constants for the round-to-integral unit.
// No dependencies.
package frti_pkg;

  typedef enum logic [1:0] {
    MODE_TRUNC = 2'd0,
    MODE_FLOOR = 2'd1,
    MODE_CEIL  = 2'd2,
    MODE_ROUND = 2'd3
  } mode_t;

  typedef struct packed {
    logic [1:0]  req_type;
    logic        is_double;
    logic [63:0] value_bits;
  } req_t;

  typedef struct packed {
    logic [63:0] result_bits;
    logic        was_fractional;
  } rsp_t;

  localparam logic [63:0] DP_ONE = 64'h3ff0_0000_0000_0000;
  localparam logic [63:0] SP_ONE = 64'h0000_0000_3f80_0000;
  localparam logic [10:0] DP_EMAX = 11'h7ff;
  localparam logic [10:0] DP_BIAS = 11'd1023;
  localparam logic [10:0] SP_EMAX = 11'h0ff;
  localparam logic [10:0] SP_BIAS = 11'd127;

endpackage

>>> sv/fp_round_to_integral_unit.sv
// fp_round_to_integral_unit: IEEE-754 binary32/binary64 round to integral.
// Depends on frti_pkg.
//
//  channel | signals                   | transfer when
//  --------+---------------------------+--------------------------------
//  request | start, busy, req (req_t)  | start && !busy at rising clk
//  result  | done, rsp (rsp_t)         | done high, one cycle per result
//
// Three register stages: S1 decodes exponent, class and shift amount;
// S2 builds the fraction mask, kept value and rounding decision;
// S3 does the 64-bit increment and result select; one item may enter
// every cycle. busy is tied low: the receiver cannot stall, so nothing
// ever backs up. rst clears the stage valid bits only.
module fp_round_to_integral_unit
  import frti_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic start,
  output logic busy,
  input  req_t req,
  output logic done,
  output rsp_t rsp
);

  // ---- stage 1: field decode ----
  logic        v1;
  logic [1:0]  mode1;
  logic        dbl1;
  logic [63:0] x1;
  logic        pass1;   // NaN, inf or no fraction bits
  logic        small1;  // magnitude below one
  logic        half1;   // exponent is bias-1
  logic        zero1;   // magnitude zero
  logic [5:0]  sh1;     // fraction bits below binary point, 1..52

  logic [63:0] xin;
  logic [10:0] expo_in, emax_in, bias_in;
  logic [5:0]  fb_in;
  logic [62:0] mag_in;

  always_comb begin
    xin     = req.is_double ? req.value_bits : {32'd0, req.value_bits[31:0]};
    emax_in = req.is_double ? DP_EMAX : SP_EMAX;
    bias_in = req.is_double ? DP_BIAS : SP_BIAS;
    fb_in   = req.is_double ? 6'd52 : 6'd23;
    expo_in = req.is_double ? xin[62:52] : {3'd0, xin[30:23]};
    mag_in  = req.is_double ? xin[62:0] : {32'd0, xin[30:0]};
  end

  logic [11:0] eb_sum;
  assign eb_sum = {1'b0, bias_in} + {6'd0, fb_in};

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= start;
    end
    mode1  <= req.req_type;
    dbl1   <= req.is_double;
    x1     <= xin;
    pass1  <= (expo_in == emax_in) || ({1'b0, expo_in} >= eb_sum);
    small1 <= expo_in < bias_in;
    half1  <= expo_in == (bias_in - 11'd1);
    zero1  <= mag_in == 63'd0;
    sh1    <= fb_in - 6'(expo_in - bias_in);
  end

  // ---- stage 2: mask and decision ----
  logic        v2, dbl2, pass2, small2, inc2, frac2;
  logic [63:0] kept2, unit2, small_res2, x2;
  logic [63:0] mask_c, sign_c, one_c;
  logic        sgn_c, rbit_c, inc_c;

  always_comb begin
    mask_c = (64'd1 << sh1) - 64'd1;
    sgn_c  = dbl1 ? x1[63] : x1[31];
    sign_c = dbl1 ? {sgn_c, 63'd0} : {32'd0, sgn_c, 31'd0};
    one_c  = dbl1 ? DP_ONE : SP_ONE;
    rbit_c = |(x1 & (mask_c ^ (mask_c >> 1)));
    unique case (mode_t'(mode1))
      MODE_TRUNC: inc_c = 1'b0;
      MODE_FLOOR: inc_c = sgn_c;
      MODE_CEIL:  inc_c = !sgn_c;
      MODE_ROUND: inc_c = rbit_c;
      default:    inc_c = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else begin
      v2 <= v1;
    end
    dbl2   <= dbl1;
    x2     <= x1;
    pass2  <= pass1 || (small1 && zero1) || (!small1 && ((x1 & mask_c) == 64'd0));
    small2 <= small1;
    frac2  <= !(pass1 || (small1 && zero1) || (!small1 && ((x1 & mask_c) == 64'd0)));
    kept2  <= x1 & ~mask_c;
    unit2  <= mask_c + 64'd1;
    inc2   <= inc_c;
    unique case (mode_t'(mode1))
      MODE_TRUNC: small_res2 <= sign_c;
      MODE_FLOOR: small_res2 <= sgn_c ? (sign_c | one_c) : 64'd0;
      MODE_CEIL:  small_res2 <= sgn_c ? sign_c : one_c;
      MODE_ROUND: small_res2 <= half1 ? (sign_c | one_c) : sign_c;
      default:    small_res2 <= sign_c;
    endcase
  end

  // ---- stage 3: increment and select ----
  logic        v3;
  rsp_t        r3;
  logic [63:0] sum_c, res_c;

  always_comb begin
    sum_c = inc2 ? kept2 + unit2 : kept2;
    priority if (pass2) begin
      res_c = x2;
    end else if (small2) begin
      res_c = small_res2;
    end else begin
      res_c = sum_c;
    end
    if (!dbl2) begin
      res_c[63:32] = 32'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else begin
      v3 <= v2;
    end
    r3.result_bits    <= res_c;
    r3.was_fractional <= frac2;
  end

  assign busy = 1'b0;
  assign done = v3;
  assign rsp  = r3;

endmodule

>>> sv/frti_checker.sv
// frti_checker: port-level assertions for fp_round_to_integral_unit.
// Depends on frti_pkg; bound to the top level below.
module frti_checker
  import frti_pkg::*;
(
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input req_t req,
  input logic done,
  input rsp_t rsp
);

  a_lat: assert property (@(posedge clk) disable iff (rst)
    start && !busy |-> ##3 done) else $error("result missing after 3 cycles");

  a_nospur: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, 3)) else $error("result without request");

  a_sp_hi: assert property (@(posedge clk) disable iff (rst)
    start && !busy && !req.is_double |-> ##3 (rsp.result_bits[63:32] == 32'd0))
    else $error("binary32 result has upper bits set");

  a_nan: assert property (@(posedge clk) disable iff (rst)
    start && !busy && req.is_double && (req.value_bits[62:52] == 11'h7ff)
    |-> ##3 !rsp.was_fractional) else $error("NaN/inf flagged fractional");

endmodule

bind fp_round_to_integral_unit frti_checker u_frti_checker (.*);

>>> dv/fp_round_to_integral_unit_test.sv
// Testbench for fp_round_to_integral_unit: directed and random operands in
// every rounding mode, each result checked against a bit-level predictor.
// Depends on frti_pkg and fp_round_to_integral_unit.
`timescale 1ns / 100ps

module fp_round_to_integral_unit_test;
  import frti_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  req_t req = '0;
  logic done;
  rsp_t rsp;

  rsp_t pending_rsp[$];
  int   error_count = 0;

  fp_round_to_integral_unit DUT (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .req(req), .done(done), .rsp(rsp)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Rounding on one precision. fb: fraction width, eb: exponent width.
  function automatic logic [64:0] round_core(logic [63:0] x, mode_t mode,
                                             int fb, int eb);
    logic [63:0] emax, bias, signbit, sgn, mag, expo, one, mask, kept, unit, r;
    int sh;
    emax = (64'd1 << eb) - 1;
    bias = emax >> 1;
    signbit = 64'd1 << (fb + eb);
    sgn = x & signbit;
    mag = x & (signbit - 1);
    expo = (x >> fb) & emax;
    one = bias << fb;
    if (expo == emax || expo >= bias + fb) return {x, 1'b0};
    if (expo < bias) begin
      if (mag == 0) return {x, 1'b0};
      case (mode)
        MODE_TRUNC: r = sgn;
        MODE_FLOOR: r = (sgn != 0) ? (sgn | one) : 64'd0;
        MODE_CEIL:  r = (sgn != 0) ? sgn : one;
        default:    r = (expo == bias - 1) ? (sgn | one) : sgn;
      endcase
      return {r, 1'b1};
    end
    sh = fb - int'(expo - bias);
    mask = (64'd1 << sh) - 1;
    if ((x & mask) == 0) return {x, 1'b0};
    kept = x & ~mask;
    unit = 64'd1 << sh;
    case (mode)
      MODE_TRUNC: r = kept;
      MODE_FLOOR: r = (sgn != 0) ? kept + unit : kept;
      MODE_CEIL:  r = (sgn != 0) ? kept : kept + unit;
      default:    r = x[sh-1] ? kept + unit : kept;
    endcase
    return {r, 1'b1};
  endfunction

  function automatic rsp_t predict_integral(req_t r);
    logic [64:0] o;
    rsp_t p;
    if (r.is_double) o = round_core(r.value_bits, mode_t'(r.req_type), 52, 11);
    else begin
      o = round_core({32'd0, r.value_bits[31:0]}, mode_t'(r.req_type), 23, 8);
      o[64:33] = '0;
    end
    p.result_bits = o[64:1];
    p.was_fractional = o[0];
    return p;
  endfunction

  // One transfer; start stays high across back-to-back items.
  task automatic send_item(logic [1:0] mode, logic dbl, logic [63:0] bits);
    int gap;
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 8);
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req <= '{req_type: mode, is_double: dbl, value_bits: bits};
    start <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    pending_rsp.push_back(predict_integral('{mode, dbl, bits}));
    @(negedge clk);
  endtask

  // Result checker; done is sampled at the rising edge.
  always @(posedge clk) begin
    if (!rst && done) begin
      if (pending_rsp.size() == 0) begin
        $display("%0t: unexpected result %h/%b", $time, rsp.result_bits,
                 rsp.was_fractional);
        error_count++;
      end else begin
        rsp_t e;
        e = pending_rsp.pop_front();
        if (e.result_bits !== rsp.result_bits) begin
          $display("%0t: result_bits expected %h actual %h", $time,
                   e.result_bits, rsp.result_bits);
          error_count++;
        end
        if (e.was_fractional !== rsp.was_fractional) begin
          $display("%0t: was_fractional expected %b actual %b", $time,
                   e.was_fractional, rsp.was_fractional);
          error_count++;
        end
      end
    end
  end

  task automatic test_directed;
    logic [63:0] dv[$];
    logic [63:0] sv[$];
    dv = '{64'h0, 64'h8000_0000_0000_0000, 64'h7ff0_0000_0000_0000,
           64'h7ff8_0000_0000_0001, 64'h3fe0_0000_0000_0000,
           64'hbfd0_0000_0000_0000, 64'h4004_0000_0000_0000,
           64'hc00c_0000_0000_0000, 64'h4330_0000_0000_0001,
           64'h0000_0000_0000_0001, 64'hffff_ffff_ffff_ffff};
    sv = '{64'hffff_ffff_3fc0_0000, 64'h3f00_0000, 64'hbe80_0000,
           64'h4b00_0001, 64'h7f80_0000, 64'hff80_0001, 64'hc020_0000,
           64'h3fff_ffff, 64'h8000_0001};
    foreach (dv[i]) send_item(2'(i), 1'b1, dv[i]);
    foreach (sv[i]) send_item(2'(i + 1), 1'b0, sv[i]);
    send_item(MODE_ROUND, 1'b1, 64'h3fdf_ffff_ffff_ffff);
    send_item(MODE_CEIL, 1'b1, 64'h432f_ffff_ffff_ffff);
  endtask

  // Random operands, most with exponents near the binary point.
  task automatic test_random;
    logic [63:0] v;
    logic dbl;
    repeat (1100) begin
      dbl = 1'($urandom_range(0, 1));
      v = {$urandom, $urandom};
      if ($urandom_range(0, 9) < 8) begin
        if (dbl) v[62:52] = 11'(1023 + $urandom_range(0, 56) - 3);
        else v[30:23] = 8'(127 + $urandom_range(0, 27) - 3);
      end
      send_item(2'($urandom_range(0, 3)), dbl, v);
    end
  endtask

  initial begin
    int wait_cycles;
    repeat (5) @(negedge clk);
    rst <= 1'b0;
    test_directed();
    test_random();
    start <= 1'b0;
    wait_cycles = 0;
    while (pending_rsp.size() != 0 && wait_cycles < 1000) begin
      @(posedge clk);
      wait_cycles++;
    end
    repeat (6) @(posedge clk);
    if (error_count == 0 && pending_rsp.size() == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

  initial begin
    #2000000;
    $display("Test completed with failures");
    $finish;
  end

endmodule
